// File: hdl/dms_pkg.sv
// shared types and constants for the doublet maneuver sequencer
`default_nettype none
package dms_pkg;

  localparam int unsigned QONE = 16384;

  // register indexes
  localparam logic [2:0] REG_HALF   = 3'd0;
  localparam logic [2:0] REG_SETTLE = 3'd1;
  localparam logic [2:0] REG_EGAIN  = 3'd2;
  localparam logic [2:0] REG_LGAIN  = 3'd3;
  localparam logic [2:0] REG_SWLVL  = 3'd4;
  localparam logic [2:0] REG_TURN   = 3'd5;
  localparam logic [2:0] REG_END    = 3'd6;

  // maneuver phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_ARMED  = 3'd1;
  localparam logic [2:0] PH_FIRST  = 3'd2;
  localparam logic [2:0] PH_SECOND = 3'd3;
  localparam logic [2:0] PH_SETTLE = 3'd4;
  localparam logic [2:0] PH_AIL1   = 3'd5;
  localparam logic [2:0] PH_AIL2   = 3'd6;
  localparam logic [2:0] PH_AIL3   = 3'd7;

  // held pitch command codes
  localparam logic [1:0] HPC_ZERO  = 2'd0;
  localparam logic [1:0] HPC_PLUS  = 2'd1;
  localparam logic [1:0] HPC_MINUS = 2'd2;

  typedef struct packed {
    logic [31:0]        now_us;
    logic [11:0]        mode_channel;
    logic [11:0]        trigger_channel;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] stick_roll;
    logic signed [15:0] stick_pitch;
    logic signed [15:0] stick_yaw;
    logic signed [15:0] stick_throttle;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] aileron_cmd;
    logic signed [15:0] elevator_cmd;
    logic signed [15:0] rudder_cmd;
    logic signed [15:0] throttle_cmd;
    logic [2:0]         phase_out;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture input transaction
    logic mul;     // one multiply step
    logic div_go;  // start divider
    logic div_stp; // one divider step
    logic fin;     // compute sequencing and result
    logic [2:0] mstep;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_sts_t;

  // saturate a signed value to plus or minus one
  function automatic logic signed [15:0] sat1(input logic signed [33:0] v);
    logic signed [15:0] r;
    if (v > 34'sd16384) r = 16'sd16384;
    else if (v < -34'sd16384) r = -16'sd16384;
    else r = v[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/doublet_maneuver_sequencer_unit.sv
// top level of the doublet maneuver sequencer
// sequence per transaction: capture, 5 multiply steps, divider start,
// bit-serial divider steps, then finish; the result is registered and held
// until taken, and no new transaction is accepted while one is in flight or
// its result waits; reset: synchronous active low, registers
// return to defaults, phase idle
`default_nettype none
module doublet_maneuver_sequencer_unit
  import dms_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [24:0] cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  dms_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  dms_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd), .sts(sts),
    .out_data(out_data), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // no new transaction while a result waits
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");

  // result holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("result changed under stall");

  // commands are mutually exclusive
  a_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.mul, cmd.div_go, cmd.div_stp, cmd.fin}))
    else $error("overlapping datapath commands");

endmodule
`default_nettype wire

// File: hdl/dms_ctrl.sv
// controller state machine sequencing one transaction through the datapath
`default_nettype none
module dms_ctrl
  import dms_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  wire logic    out_stall,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_DGO  = 6'b000100,
    S_DIV  = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] mstep_r, mstep_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    mstep_nxt = mstep_r;
    cmd = '0;
    cmd.mstep = mstep_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          mstep_nxt = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        mstep_nxt = mstep_r + 3'd1;
        if (mstep_r == 3'd4) state_nxt = S_DGO;
      end
      S_DGO: begin
        cmd.div_go = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_stp = 1'b1;
        if (sts.div_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mstep_r <= '0;
    end else begin
      state_r <= state_nxt;
      mstep_r <= mstep_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/dms_dp.sv
// datapath: roll sine, divider, phase sequencing and command mixing
`default_nettype none
module dms_dp
  import dms_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire in_item_t     in_data,
  input  wire dp_cmd_t      cmd,
  output dp_sts_t           sts,
  output out_item_t         out_data,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [24:0]  cfg_wdata
);

  // configuration registers
  logic [23:0] half_r;
  logic [24:0] settle_r;
  logic [14:0] egain_r, lgain_r;
  logic [11:0] swlvl_r;
  logic signed [15:0] turn_r, end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r   <= 24'd400000;
      settle_r <= 25'd3000000;
      egain_r  <= 15'd13107;
      lgain_r  <= 15'd9830;
      swlvl_r  <= 12'd1500;
      turn_r   <= 16'sd11583;
      end_r    <= -16'sd1428;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HALF:   half_r   <= cfg_wdata[23:0];
        REG_SETTLE: settle_r <= cfg_wdata;
        REG_EGAIN:  egain_r  <= cfg_wdata[14:0];
        REG_LGAIN:  lgain_r  <= cfg_wdata[14:0];
        REG_SWLVL:  swlvl_r  <= cfg_wdata[11:0];
        REG_TURN:   turn_r   <= cfg_wdata[15:0];
        REG_END:    end_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // captured transaction
  in_item_t it_r;
  always_ff @(posedge clk) begin
    if (cmd.load) it_r <= in_data;
  end

  // shared multiplier, one product per step
  logic signed [31:0] p_r;
  logic signed [32:0] n_r;
  logic signed [18:0] b_r;
  logic signed [37:0] d_r;
  logic signed [18:0] ma, mb;
  logic signed [37:0] prod;
  logic signed [31:0] mdiff;

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mstep)
      3'd0: begin ma = 19'(it_r.quat_w); mb = 19'(it_r.quat_x); end
      3'd1: begin ma = 19'(it_r.quat_y); mb = 19'(it_r.quat_z); end
      3'd2: begin ma = 19'(it_r.quat_x); mb = 19'(it_r.quat_z); end
      3'd3: begin ma = 19'(it_r.quat_w); mb = 19'(it_r.quat_y); end
      default: begin ma = b_r; mb = b_r; end
    endcase
    prod = ma * mb;
    mdiff = p_r - 32'(prod);
  end

  // accumulate n, m, then b and the denominator
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      case (cmd.mstep)
        3'd0: p_r <= 32'(prod);
        3'd1: n_r <= 33'(p_r) + 33'(prod);
        3'd2: p_r <= 32'(prod);
        3'd3: b_r <= 19'(mdiff >>> 13);
        default: d_r <= (38'sd1 <<< 28) - prod;
      endcase
    end
  end

  // restoring divider over |n| * 2^15 / |d|
  logic [46:0] dvd_r;
  logic [36:0] dmag_r;
  logic [36:0] rem_r;
  logic [46:0] quo_r;
  logic [5:0]  cnt_r;
  logic        neg_r;
  logic [38:0] trial;

  assign trial = {1'b0, rem_r, dvd_r[46]} - {2'b0, dmag_r};
  assign sts.div_done = (cnt_r == 6'd0);

  always_ff @(posedge clk) begin
    if (cmd.div_go) begin
      dvd_r  <= {(n_r < 0) ? 32'(-n_r) : 32'(n_r), 15'd0};
      dmag_r <= (d_r < 0) ? 37'(-d_r) : 37'(d_r);
      neg_r  <= (n_r < 0) ^ (d_r < 0);
      rem_r  <= '0;
      quo_r  <= '0;
      cnt_r  <= 6'd47;
    end else if (cmd.div_stp && cnt_r != 6'd0) begin
      dvd_r <= dvd_r << 1;
      cnt_r <= cnt_r - 6'd1;
      if (!trial[38]) begin
        rem_r <= trial[36:0];
        quo_r <= {quo_r[45:0], 1'b1};
      end else begin
        rem_r <= {rem_r[35:0], dvd_r[46]};
        quo_r <= {quo_r[45:0], 1'b0};
      end
    end
  end

  // roll sine, saturated
  logic signed [16:0] roll;
  always_comb begin
    if (d_r == '0) begin
      if (n_r > 0) roll = 17'sd32767;
      else if (n_r < 0) roll = -17'sd32768;
      else roll = '0;
    end else if (!neg_r) begin
      roll = (quo_r > 47'd32767) ? 17'sd32767 : 17'(quo_r);
    end else begin
      roll = (quo_r > 47'd32768) ? -17'sd32768 : -17'(quo_r);
    end
  end

  // sequencing state
  logic [2:0]  phase_r, ph;
  logic [31:0] stamp_r, stamp_n;
  logic        pol_r, pol_n;
  logic [1:0]  hpc_r, hpc;
  logic        thi, tlo, mhi;
  logic [31:0] el;
  logic [25:0] full;
  logic [26:0] fset;
  logic signed [1:0] hi, lo, da, dr, de;
  logic signed [16:0] rlo, rhi;
  out_item_t   res;

  always_comb begin
    thi = it_r.trigger_channel > swlvl_r;
    tlo = it_r.trigger_channel < swlvl_r;
    mhi = it_r.mode_channel > swlvl_r;
    full = {2'b0, half_r} + {2'b0, half_r};
    fset = {1'b0, full} + {2'b0, settle_r};
    ph = thi ? PH_IDLE : phase_r;
    stamp_n = stamp_r;
    pol_n = pol_r;
    el = it_r.now_us - stamp_r;
    if (tlo && ph == PH_ARMED) begin
      stamp_n = it_r.now_us;
      el = '0;
      pol_n = ~pol_r;
    end
    hi = pol_n ? 2'sd1 : -2'sd1;
    lo = -hi;
    rlo = pol_n ? -roll : roll;
    rhi = pol_n ? roll : -roll;
    hpc = hpc_r;
    da = '0;
    dr = '0;
    if (mhi) begin
      case (ph)
        PH_IDLE: begin hpc = HPC_ZERO; if (thi) ph = PH_ARMED; end
        PH_ARMED: begin
          hpc = HPC_ZERO;
          if (tlo) begin hpc = pol_n ? HPC_PLUS : HPC_MINUS; ph = PH_FIRST; end
        end
        PH_FIRST: begin
          hpc = pol_n ? HPC_PLUS : HPC_MINUS;
          if (el >= 32'(half_r)) begin
            hpc = pol_n ? HPC_MINUS : HPC_PLUS;
            ph = PH_SECOND;
          end
        end
        PH_SECOND: begin
          hpc = pol_n ? HPC_MINUS : HPC_PLUS;
          if (el >= 32'(full)) begin hpc = HPC_ZERO; ph = PH_IDLE; end
        end
        default: ;
      endcase
    end else begin
      hpc = HPC_ZERO;
      case (ph)
        PH_IDLE: if (thi) ph = PH_ARMED;
        PH_ARMED: if (tlo) begin dr = hi; ph = PH_FIRST; end
        PH_FIRST: begin
          dr = hi;
          if (el >= 32'(half_r)) begin dr = lo; ph = PH_SECOND; end
        end
        PH_SECOND: begin
          dr = lo;
          if (el >= 32'(full)) begin dr = '0; ph = PH_SETTLE; end
        end
        PH_SETTLE: if (el >= 32'(fset)) begin da = lo; ph = PH_AIL1; end
        PH_AIL1: begin
          da = lo;
          if (rlo >= 17'(turn_r)) begin da = hi; ph = PH_AIL2; end
        end
        PH_AIL2: begin
          da = hi;
          if (rhi >= 17'(turn_r)) begin da = lo; ph = PH_AIL3; end
        end
        default: begin
          da = lo;
          if (rlo >= 17'(end_r)) begin da = '0; ph = PH_IDLE; end
        end
      endcase
    end
    de = (hpc == HPC_PLUS) ? 2'sd1 : ((hpc == HPC_MINUS) ? -2'sd1 : 2'sd0);
    if (mhi) begin
      res.aileron_cmd  = sat1(34'(it_r.stick_roll));
      res.elevator_cmd = sat1(34'(de) * 34'($signed({1'b0, egain_r}))
                              - 34'(it_r.stick_pitch));
      res.rudder_cmd   = sat1(34'(it_r.stick_yaw));
    end else begin
      res.aileron_cmd  = sat1(34'(da) * 34'($signed({1'b0, lgain_r}))
                              + 34'(it_r.stick_roll));
      res.elevator_cmd = sat1(-34'(it_r.stick_pitch));
      res.rudder_cmd   = sat1(34'(dr) * 34'($signed({1'b0, lgain_r}))
                              + 34'(it_r.stick_yaw));
    end
    res.throttle_cmd = sat1(34'(it_r.stick_throttle));
    res.phase_out = ph;
  end

  // sequencing registers and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      stamp_r <= '0;
      pol_r   <= 1'b1;
      hpc_r   <= HPC_ZERO;
    end else if (cmd.fin) begin
      phase_r <= ph;
      stamp_r <= stamp_n;
      pol_r   <= pol_n;
      hpc_r   <= hpc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) out_data <= res;
  end

endmodule
`default_nettype wire

// File: test/tb_doublet_maneuver_sequencer_unit.sv
// self-checking testbench for the doublet maneuver sequencer
`default_nettype none
module tb_doublet_maneuver_sequencer_unit;
  import dms_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [24:0] cfg_wdata;

  doublet_maneuver_sequencer_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // predictor copy of registers and sequencing state
  logic [23:0]        m_half;
  logic [24:0]        m_settle;
  logic [14:0]        m_egain, m_lgain;
  logic [11:0]        m_swlvl;
  logic signed [15:0] m_turn, m_end;
  logic [2:0]         m_phase;
  logic [31:0]        m_stamp;
  logic               m_pol;
  logic [1:0]         m_hpc;

  in_item_t  pending_items[$];
  out_item_t expected_cmds[$];
  int        n_errors;
  int        n_checked;
  int        n_sent;
  bit        quiet;      // no idling on either side
  bit        hold_send;  // sender paused
  logic [31:0] clock_us;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #400000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic longint sat_q(input longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  // roll sine in Q14 from the attitude quaternion
  function automatic longint roll_of(input longint w, x, y, z);
    longint n, m, b, d, r;
    n = w * x + y * z;
    m = x * z - w * y;
    if (m >= 0) b = m / 8192;
    else b = -((-m + 8191) / 8192);
    d = (longint'(1) << 28) - b * b;
    if (d == 0) return (n > 0) ? 32767 : ((n < 0) ? -32768 : 0);
    r = (n * 32768) / d;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic void model_reset();
    m_half = 24'd400000; m_settle = 25'd3000000; m_egain = 15'd13107;
    m_lgain = 15'd9830; m_swlvl = 12'd1500; m_turn = 16'sd11583; m_end = -16'sd1428;
    m_phase = PH_IDLE; m_stamp = '0; m_pol = 1'b1; m_hpc = HPC_ZERO;
  endfunction

  function automatic void model_write(input logic [2:0] idx, input logic [24:0] v);
    case (idx)
      REG_HALF:   m_half = v[23:0];
      REG_SETTLE: m_settle = v;
      REG_EGAIN:  m_egain = v[14:0];
      REG_LGAIN:  m_lgain = v[14:0];
      REG_SWLVL:  m_swlvl = v[11:0];
      REG_TURN:   m_turn = v[15:0];
      REG_END:    m_end = v[15:0];
      default: ;
    endcase
  endfunction

  // advance the sequencer by one transaction and return the commands
  function automatic out_item_t predict_cmds(input in_item_t it);
    out_item_t o;
    longint roll, hi, lo, ail, ele, rud, da, dr, de;
    longint unsigned elapsed, half, full;
    bit th, tl;
    roll = roll_of(it.quat_w, it.quat_x, it.quat_y, it.quat_z);
    th = it.trigger_channel > m_swlvl;
    tl = it.trigger_channel < m_swlvl;
    elapsed = 64'(32'(it.now_us - m_stamp));
    half = m_half;
    full = half + half;
    da = 0; dr = 0;
    if (th) m_phase = PH_IDLE;
    if (tl && m_phase == PH_ARMED) begin
      m_stamp = it.now_us;
      elapsed = 0;
      m_pol = ~m_pol;
    end
    hi = m_pol ? 1 : -1;
    lo = -hi;
    if (it.mode_channel > m_swlvl) begin
      case (m_phase)
        PH_IDLE: begin
          m_hpc = HPC_ZERO;
          if (th) m_phase = PH_ARMED;
        end
        PH_ARMED: begin
          m_hpc = HPC_ZERO;
          if (tl) begin
            m_hpc = hi > 0 ? HPC_PLUS : HPC_MINUS;
            m_phase = PH_FIRST;
          end
        end
        PH_FIRST: begin
          m_hpc = hi > 0 ? HPC_PLUS : HPC_MINUS;
          if (elapsed >= half) begin
            m_hpc = lo > 0 ? HPC_PLUS : HPC_MINUS;
            m_phase = PH_SECOND;
          end
        end
        PH_SECOND: begin
          m_hpc = lo > 0 ? HPC_PLUS : HPC_MINUS;
          if (elapsed >= full) begin
            m_hpc = HPC_ZERO;
            m_phase = PH_IDLE;
          end
        end
        default: ;
      endcase
      de = (m_hpc == HPC_PLUS) ? 1 : ((m_hpc == HPC_MINUS) ? -1 : 0);
      ail = sat_q(it.stick_roll);
      ele = sat_q(de * longint'(m_egain) - it.stick_pitch);
      rud = sat_q(it.stick_yaw);
    end else begin
      case (m_phase)
        PH_IDLE: if (th) m_phase = PH_ARMED;
        PH_ARMED: if (tl) begin
          dr = hi; m_phase = PH_FIRST;
        end
        PH_FIRST: begin
          dr = hi;
          if (elapsed >= half) begin
            dr = lo; m_phase = PH_SECOND;
          end
        end
        PH_SECOND: begin
          dr = lo;
          if (elapsed >= full) begin
            dr = 0; m_phase = PH_SETTLE;
          end
        end
        PH_SETTLE: if (elapsed >= full + m_settle) begin
          da = lo; m_phase = PH_AIL1;
        end
        PH_AIL1: begin
          da = lo;
          if (roll * lo >= m_turn) begin
            da = hi; m_phase = PH_AIL2;
          end
        end
        PH_AIL2: begin
          da = hi;
          if (roll * hi >= m_turn) begin
            da = lo; m_phase = PH_AIL3;
          end
        end
        default: begin
          da = lo;
          if (roll * lo >= m_end) begin
            da = 0; m_phase = PH_IDLE;
          end
        end
      endcase
      m_hpc = HPC_ZERO;
      ail = sat_q(da * longint'(m_lgain) + it.stick_roll);
      ele = sat_q(-longint'(it.stick_pitch));
      rud = sat_q(dr * longint'(m_lgain) + it.stick_yaw);
    end
    o.aileron_cmd = 16'(ail);
    o.elevator_cmd = 16'(ele);
    o.rudder_cmd = 16'(rud);
    o.throttle_cmd = 16'(sat_q(it.stick_throttle));
    o.phase_out = m_phase;
    return o;
  endfunction

  function automatic logic signed [15:0] rand_q();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 16'sd16384;
    if (r == 1) return -16'sd16384;
    if (r == 2) return 16'(16'($urandom));  // full 16-bit patterns
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  // random quaternion; most draws keep the y and z parts small
  function automatic void set_attitude(inout in_item_t it);
    int k;
    k = $urandom_range(6);
    if (k == 0) begin
      it.quat_w = rand_q(); it.quat_x = rand_q(); it.quat_y = rand_q(); it.quat_z = rand_q();
    end else begin
      it.quat_w = 16'($signed($urandom_range(32768)) - 16384);
      it.quat_x = 16'($signed($urandom_range(32768)) - 16384);
      it.quat_y = 16'($signed($urandom_range(2000)) - 1000);
      it.quat_z = 16'($signed($urandom_range(2000)) - 1000);
    end
  endfunction

  // build one transaction; trig: 0 low, 1 high, 2 equal, 3 any
  function automatic in_item_t make_item(input bit pitch, input int trig, input int step_us);
    in_item_t it;
    clock_us = clock_us + 32'(step_us);
    it.now_us = clock_us;
    it.mode_channel = pitch ? 12'($urandom_range(4095, m_swlvl + 1 > 4095 ? 4095 : m_swlvl + 1))
                            : 12'($urandom_range(m_swlvl));
    case (trig)
      0: it.trigger_channel = (m_swlvl == 0) ? 12'd0 : 12'($urandom_range(m_swlvl - 1));
      1: it.trigger_channel = (m_swlvl == 4095) ? 12'd4095 : 12'($urandom_range(4095, m_swlvl + 1));
      2: it.trigger_channel = m_swlvl;
      default: it.trigger_channel = 12'($urandom);
    endcase
    set_attitude(it);
    it.stick_roll = rand_q(); it.stick_pitch = rand_q();
    it.stick_yaw = rand_q(); it.stick_throttle = rand_q();
    return it;
  endfunction

  // wait until every queued transaction went in and all results came back
  task automatic drain();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_cmds.size() != 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [24:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    model_write(idx, v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // one full maneuver with random content
  task automatic queue_maneuver(input bit pitch);
    int n;
    int stp;
    stp = $urandom_range(3) == 0 ? int'(m_half) / 2 + 1 : 5000;
    repeat ($urandom_range(3, 1)) pending_items.push_back(make_item(pitch, 1, 5000));
    n = $urandom_range(40, 10);
    for (int i = 0; i < n; i++) begin
      in_item_t it;
      it = make_item(($urandom_range(19) == 0) ? ~pitch : pitch,
                     ($urandom_range(15) == 0) ? 3 : 0, stp);
      pending_items.push_back(it);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) n_sent <= n_sent + 1;
      if (pending_items.size() != 0 && !hold_send && (quiet || $urandom_range(99) >= 34)) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // predict on accept
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) expected_cmds.push_back(predict_cmds(in_data));
  end

  // result stall
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 34);
  end

  // monitor
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cmds.size() == 0) begin
        $error("result with no transaction outstanding");
        n_errors++;
      end else begin
        e = expected_cmds.pop_front();
        n_checked++;
        if (out_data.aileron_cmd !== e.aileron_cmd) begin
          $error("aileron_cmd exp %0d got %0d", e.aileron_cmd, out_data.aileron_cmd);
          n_errors++;
        end
        if (out_data.elevator_cmd !== e.elevator_cmd) begin
          $error("elevator_cmd exp %0d got %0d", e.elevator_cmd, out_data.elevator_cmd);
          n_errors++;
        end
        if (out_data.rudder_cmd !== e.rudder_cmd) begin
          $error("rudder_cmd exp %0d got %0d", e.rudder_cmd, out_data.rudder_cmd);
          n_errors++;
        end
        if (out_data.throttle_cmd !== e.throttle_cmd) begin
          $error("throttle_cmd exp %0d got %0d", e.throttle_cmd, out_data.throttle_cmd);
          n_errors++;
        end
        if (out_data.phase_out !== e.phase_out) begin
          $error("phase_out exp %0d got %0d", e.phase_out, out_data.phase_out);
          n_errors++;
        end
      end
    end
  end

  initial begin
    in_item_t it;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
    cfg_we = 1'b0; cfg_index = REG_HALF; cfg_wdata = '0;
    n_errors = 0; n_checked = 0; n_sent = 0; quiet = 1'b0; hold_send = 1'b0;
    clock_us = 32'hFFF0_0000;  // wraps during the run
    model_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: short timing so maneuvers finish quickly
    write_reg(REG_HALF, 25'd1);
    write_reg(REG_SETTLE, 25'd0);
    // field extremes, equal-level trigger, zero denominator
    it = make_item(1'b0, 2, 1);
    it.quat_w = 16'sd16384; it.quat_x = 16'sd8192; it.quat_y = 16'sd0;
    it.quat_z = 16'sd16384;
    it.stick_roll = 16'sd16384; it.stick_pitch = -16'sd16384;
    it.stick_yaw = 16'sd16384; it.stick_throttle = -16'sd16384;
    pending_items.push_back(it);
    it.quat_x = -16'sd16384; it.stick_throttle = 16'h7FFF; it.stick_pitch = 16'h8000;
    pending_items.push_back(it);
    it = make_item(1'b1, 2, 1);
    it.mode_channel = 12'hFFF; it.trigger_channel = 12'hFFF; it.now_us = 32'hFFFF_FFFF;
    // most negative quaternion parts, largest numerator
    it.quat_w = 16'h8000; it.quat_x = 16'h8000; it.quat_y = 16'h8000; it.quat_z = 16'h8000;
    pending_items.push_back(it);
    it.trigger_channel = 12'h000; it.now_us = 32'h0;
    pending_items.push_back(it);
    // full pitch doublet, then a lateral one with mode switch mid-maneuver
    for (int i = 0; i < 6; i++) pending_items.push_back(make_item(1'b1, i == 0, 1));
    for (int i = 0; i < 10; i++) pending_items.push_back(make_item(i == 4, i == 0, 1));
    // pause until all outstanding results are in
    drain();

    // random phases over several register settings, extremes among them
    for (int ph = 0; ph < 8; ph++) begin
      quiet = (ph == 3);
      case (ph)
        0: begin
          write_reg(REG_HALF, 25'd10000); write_reg(REG_SETTLE, 25'd20000);
          write_reg(REG_EGAIN, 25'd16384); write_reg(REG_LGAIN, 25'd16384);
          write_reg(REG_SWLVL, 25'd1500); write_reg(REG_TURN, 25'h0_3000);
          write_reg(REG_END, 25'h1_FA00);
        end
        1: begin
          write_reg(REG_EGAIN, 25'd0); write_reg(REG_LGAIN, 25'd0);
          write_reg(REG_SWLVL, 25'd0); write_reg(REG_TURN, 25'h0_C000);
          write_reg(REG_END, 25'h0_4000);
        end
        2: begin
          write_reg(REG_SWLVL, 25'd4095); write_reg(REG_HALF, 25'hFF_FFFF);
          write_reg(REG_SETTLE, 25'd20000000);
        end
        3: begin
          write_reg(REG_HALF, 25'd1); write_reg(REG_SETTLE, 25'd0);
          write_reg(REG_SWLVL, 25'd2048); write_reg(REG_LGAIN, 25'd9830);
          write_reg(REG_EGAIN, 25'd13107); write_reg(REG_TURN, 25'h1_C000);
          write_reg(REG_END, 25'h1_C000);
        end
        4: begin
          write_reg(REG_HALF, 25'd7000); write_reg(REG_SETTLE, 25'd1000);
          write_reg(REG_TURN, 25'd2000); write_reg(REG_END, 25'h1_FFFF);
        end
        5: write_reg(REG_SWLVL, 25'h1FF_F05C);  // masked wide write
        6: write_reg(3'd7, 25'h155_5555);       // index outside the map
        default: write_reg(REG_TURN, 25'h0_4000);
      endcase
      while (pending_items.size() < 160) begin
        if ($urandom_range(4) == 0)
          pending_items.push_back(make_item($urandom_range(1), 3, $urandom_range(50000)));
        else
          queue_maneuver($urandom_range(2) == 0);
      end
      drain();
    end

    $display("checked %0d results from %0d transactions over 9 register settings",
             n_checked, n_sent);
    $display("covered pitch and lateral doublets, aileron 1-2-1 and timestamp wrap");
    if (n_errors == 0 && expected_cmds.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
